// ===== hdl/kps_pkg.sv =====
// Package for the keyframe pose sequencer: sizes, codes and shared types.
// Used by kps_ctrl, kps_datapath and keyframe_pose_sequencer.
package kps_pkg;

  localparam int MAX_KF  = 32;
  localparam int IDX_W   = $clog2(MAX_KF);
  localparam int CNT_W   = $clog2(MAX_KF + 1);
  localparam int ANG_W   = 10;
  localparam int DUR_W   = 16;
  localparam int TOT_W   = DUR_W + IDX_W;
  localparam int TIME_W  = 32;
  localparam int OFS_W   = 24;
  localparam int DVD_W   = TIME_W + 1;
  localparam int SEG_W   = 5;
  localparam int NUM_W   = 28;
  localparam int STEP_W  = 6;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_POSE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_OFFSET  = 2'd0,
    REG_REVERSE = 2'd1,
    REG_INTERP  = 2'd2,
    REG_NONE    = 2'd3
  } reg_e;

  typedef struct packed {
    logic signed [ANG_W-1:0] knee;
    logic signed [ANG_W-1:0] femur;
    logic signed [ANG_W-1:0] hip;
    logic        [DUR_W-1:0] dur;
  } kf_t;

  typedef struct packed {
    logic add;
    logic clr;
    logic mod_start;
    logic div_step;
    logic rev;
    logic wchk;
    logic rd_next;
    logic lat_a;
    logic lat_b;
    logic bmul;
    logic bload;
    logic bstore;
    logic out_load;
  } kps_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic div_last;
    logic hit;
    logic walk_end;
    logic interp;
    logic joint_last;
    logic out_free;
  } kps_sts_t;

endpackage

// ===== hdl/keyframe_pose_sequencer.sv =====
// Keyframe pose sequencer: add and clear finish in idle as they are accepted.
// A pose query runs the remainder steps, a mirror step, a read and a check
// per keyframe walked, a fetch of the next keyframe, then a hold or a blend
// per joint (one shared restoring divider), and an output load. Queries run
// one at a time; a finished pose waits in the output register while the
// next transaction is accepted. Reset (async, active low) empties the table
// and zeroes config and output valid; keyframe memory and payload are not reset.
module keyframe_pose_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [kps_pkg::OFS_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic signed [kps_pkg::ANG_W-1:0] knee_in_i,
  input  logic signed [kps_pkg::ANG_W-1:0] femur_in_i,
  input  logic signed [kps_pkg::ANG_W-1:0] hip_in_i,
  input  logic [kps_pkg::DUR_W-1:0]        duration_i,
  input  logic [kps_pkg::TIME_W-1:0]       now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [kps_pkg::ANG_W-1:0] knee_out_o,
  output logic signed [kps_pkg::ANG_W-1:0] femur_out_o,
  output logic signed [kps_pkg::ANG_W-1:0] hip_out_o,
  output logic [kps_pkg::SEG_W-1:0]        segment_o
);
  import kps_pkg::*;

  // Command and status between sequencer and datapath.
  kps_cmd_t cmd;
  kps_sts_t sts;

  // Sequencer: accept a transaction in idle, then step the query through
  // remainder, segment walk and per-joint blend.
  kps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: hold the table, the registers and the result.
  kps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .knee_in_i   (knee_in_i),
    .femur_in_i  (femur_in_i),
    .hip_in_i    (hip_in_i),
    .duration_i  (duration_i),
    .now_ms_i    (now_ms_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .knee_out_o  (knee_out_o),
    .femur_out_o (femur_out_o),
    .hip_out_o   (hip_out_o),
    .segment_o   (segment_o)
  );

endmodule

// ===== hdl/kps_datapath.sv =====
// Datapath: keyframe memory, config registers, shared restoring divider,
// blend multipliers and the output register. Depends on kps_pkg.
module kps_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [kps_pkg::OFS_W-1:0]    cfg_data_i,
  input  logic signed [kps_pkg::ANG_W-1:0] knee_in_i,
  input  logic signed [kps_pkg::ANG_W-1:0] femur_in_i,
  input  logic signed [kps_pkg::ANG_W-1:0] hip_in_i,
  input  logic [kps_pkg::DUR_W-1:0]    duration_i,
  input  logic [kps_pkg::TIME_W-1:0]   now_ms_i,
  input  kps_pkg::kps_cmd_t            cmd_i,
  output kps_pkg::kps_sts_t            sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [kps_pkg::ANG_W-1:0] knee_out_o,
  output logic signed [kps_pkg::ANG_W-1:0] femur_out_o,
  output logic signed [kps_pkg::ANG_W-1:0] hip_out_o,
  output logic [kps_pkg::SEG_W-1:0]    segment_o
);
  import kps_pkg::*;

  kf_t                     mem [MAX_KF];
  kf_t                     rd_q;
  kf_t                     a_q, b_q;
  logic [OFS_W-1:0]        offset_q;
  logic                    rev_q, interp_q;
  logic [CNT_W-1:0]        count_q;
  logic [TOT_W-1:0]        total_q;
  logic [IDX_W-1:0]        idx_q, raddr;
  logic [CNT_W-1:0]        idx_inc, nxt;
  logic [TOT_W-1:0]        s_q, dvs_q, rem_q;
  logic [DVD_W-1:0]        dvd_q;
  logic [STEP_W-1:0]       step_q;
  logic [1:0]              joint_q;
  logic                    neg_q;
  logic signed [NUM_W-2:0] p1_q;
  logic signed [NUM_W-1:0] p2_q;
  logic signed [ANG_W-1:0] res_q [3];
  logic                    out_valid_q;

  logic [TOT_W:0]          trial;
  logic                    qbit;
  logic signed [ANG_W-1:0] aj, bj;
  logic signed [ANG_W:0]   diff;
  logic signed [DUR_W:0]   dsx, ssx;
  logic signed [NUM_W-1:0] sum;
  logic [NUM_W-1:0]        mag;
  logic [ANG_W-1:0]        quo;
  logic signed [ANG_W-1:0] bval;

  assign idx_inc = {1'b0, idx_q} + CNT_W'(1);
  assign nxt     = (idx_inc < count_q) ? idx_inc : '0;
  assign raddr   = cmd_i.rd_next ? nxt[IDX_W-1:0] : idx_q;

  always_comb begin
    unique case (joint_q)
      2'd0:    begin aj = a_q.knee;  bj = b_q.knee;  end
      2'd1:    begin aj = a_q.femur; bj = b_q.femur; end
      default: begin aj = a_q.hip;   bj = b_q.hip;   end
    endcase
  end

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign diff  = $signed({bj[ANG_W-1], bj}) - $signed({aj[ANG_W-1], aj});
  assign dsx   = $signed({1'b0, a_q.dur});
  assign ssx   = $signed({1'b0, s_q[DUR_W-1:0]});
  assign sum   = $signed({p1_q[NUM_W-2], p1_q}) + p2_q;
  assign mag   = sum[NUM_W-1] ? NUM_W'(-sum) : NUM_W'(sum);
  assign quo   = dvd_q[ANG_W-1:0];
  assign bval  = !interp_q ? aj : (neg_q ? $signed(-quo) : $signed(quo));

  // Keyframe memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add && (count_q < CNT_W'(MAX_KF))) begin
      mem[count_q[IDX_W-1:0]] <= '{knee: knee_in_i, femur: femur_in_i,
                                   hip: hip_in_i, dur: duration_i};
    end
    rd_q <= mem[raddr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      dvd_q  <= DVD_W'(now_ms_i) + DVD_W'(offset_q);
      rem_q  <= '0;
      dvs_q  <= total_q;
      step_q <= STEP_W'(DVD_W);
    end else if (cmd_i.bload) begin
      dvd_q  <= {mag, (DVD_W-NUM_W)'(0)};
      rem_q  <= '0;
      dvs_q  <= TOT_W'(a_q.dur);
      neg_q  <= sum[NUM_W-1];
      step_q <= STEP_W'(NUM_W);
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], qbit};
      rem_q  <= qbit ? TOT_W'(trial - {1'b0, dvs_q}) : trial[TOT_W-1:0];
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.rev) begin
      s_q   <= rev_q ? total_q - rem_q : rem_q;
      idx_q <= '0;
    end else if (cmd_i.wchk && !sts_o.hit) begin
      s_q   <= s_q - TOT_W'(rd_q.dur);
      idx_q <= idx_inc[IDX_W-1:0];
    end
    if (cmd_i.lat_a) a_q <= rd_q;
    if (cmd_i.lat_b) begin
      b_q     <= rd_q;
      joint_q <= '0;
    end
    if (cmd_i.bmul) begin
      p1_q <= (NUM_W-1)'(aj * dsx);
      p2_q <= NUM_W'(ssx * diff);
    end
    if (cmd_i.bstore) begin
      res_q[joint_q] <= bval;
      if (joint_q != 2'd2) joint_q <= joint_q + 2'd1;
    end
    if (cmd_i.out_load) begin
      knee_out_o  <= res_q[0];
      femur_out_o <= res_q[1];
      hip_out_o   <= res_q[2];
      segment_o   <= SEG_W'(idx_q);
    end
  end

  // Control-side registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      rev_q       <= 1'b0;
      interp_q    <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_OFFSET:  offset_q <= cfg_data_i;
          REG_REVERSE: rev_q    <= cfg_data_i[0];
          REG_INTERP:  interp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        count_q <= '0;
        total_q <= '0;
      end else if (cmd_i.add && (count_q < CNT_W'(MAX_KF))) begin
        count_q <= count_q + CNT_W'(1);
        total_q <= total_q + TOT_W'(duration_i);
      end
      out_valid_q <= cmd_i.out_load || (out_valid_q && !out_ready_i);
    end
  end

  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.div_last   = (step_q == STEP_W'(1));
  assign sts_o.hit        = (s_q < TOT_W'(rd_q.dur));
  assign sts_o.walk_end   = (idx_inc == count_q);
  assign sts_o.interp     = interp_q;
  assign sts_o.joint_last = (joint_q == 2'd2);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;

endmodule

// ===== hdl/kps_ctrl.sv =====
// Controller: one-hot sequencer for add, clear and pose transactions.
// Drives kps_datapath through kps_cmd_t; depends on kps_pkg.
module kps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        kind_i,
  output logic              in_ready_o,
  input  kps_pkg::kps_sts_t sts_i,
  output kps_pkg::kps_cmd_t cmd_o
);
  import kps_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MOD   = 12'b000000000010,
    S_REV   = 12'b000000000100,
    S_WRD   = 12'b000000001000,
    S_WCHK  = 12'b000000010000,
    S_NRD   = 12'b000000100000,
    S_NLAT  = 12'b000001000000,
    S_BMUL  = 12'b000010000000,
    S_BLOAD = 12'b000100000000,
    S_BDIV  = 12'b001000000000,
    S_BSTO  = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_e'(kind_i))
            KIND_ADD:   cmd_o.add = 1'b1;
            KIND_CLEAR: cmd_o.clr = 1'b1;
            KIND_POSE: begin
              if (!sts_i.total_zero) begin
                cmd_o.mod_start = 1'b1;
                state_d = S_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_REV;
      end
      S_REV: begin
        cmd_o.rev = 1'b1;
        state_d = S_WRD;
      end
      S_WRD: state_d = S_WCHK;
      S_WCHK: begin
        cmd_o.wchk = 1'b1;
        if (sts_i.hit) begin
          cmd_o.lat_a = 1'b1;
          state_d = S_NRD;
        end else if (sts_i.walk_end) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_WRD;
        end
      end
      S_NRD: begin
        cmd_o.rd_next = 1'b1;
        state_d = S_NLAT;
      end
      S_NLAT: begin
        cmd_o.lat_b = 1'b1;
        state_d = S_BMUL;
      end
      S_BMUL: begin
        if (sts_i.interp) begin
          cmd_o.bmul = 1'b1;
          state_d = S_BLOAD;
        end else begin
          cmd_o.bstore = 1'b1;
          if (sts_i.joint_last) state_d = S_FIN;
        end
      end
      S_BLOAD: begin
        cmd_o.bload = 1'b1;
        state_d = S_BDIV;
      end
      S_BDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_BSTO;
      end
      S_BSTO: begin
        cmd_o.bstore = 1'b1;
        state_d = sts_i.joint_last ? S_FIN : S_BMUL;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
